// File: rtl/core/trs_pkg.sv
// Package for the TRS model-matrix builder: payload types, fixed-point
// constants, arctangent table and small arithmetic helpers. No dependencies.
package trs_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int TRIG_ITERATIONS = 18;
    localparam int ATAN_ENTRIES    = 30;
    localparam int NUM_STEPS = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                               TRIG_ITERATIONS : ATAN_ENTRIES;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [26:0]        DEG_TO_RAD_Q32  = 27'd74961321;
    // full turn and quarter turn in input units
    localparam logic signed [40:0] FULL_TURN = 41'sd360 <<< FRAC_BITS;
    localparam logic signed [40:0] QUARTER   = 41'sd90 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE_FX    = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } pose_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] entry_row0;
        logic signed [31:0] entry_row1;
        logic signed [31:0] entry_row2;
        logic signed [31:0] entry_row3;
        logic               last_column;
    } column_t;

    // trunc(atan(2^-i) * 2^30)
    function automatic logic signed [33:0] atan_q30(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
                3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
                6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
                9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
                12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
                15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
                18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
                21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
                24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
                27: t = 32'h00000007; 28: t = 32'h00000003; 29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            return signed'({2'b00, t});
        end
    endfunction

    // rounded fixed-point product, kept wide
    function automatic logic signed [47:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
            return 48'(p >>> FRAC_BITS);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'(SAT_MAX)) return SAT_MAX;
            else if (v < 48'(SAT_MIN)) return SAT_MIN;
            else return v[31:0];
        end
    endfunction

    // Q3.30 to FRAC_BITS with rounding, clamped to +/-1.0
    function automatic logic signed [31:0] to_frac(input logic signed [33:0] q);
        logic signed [34:0] v;
        begin
            v = (35'(q) + (35'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (v > 35'(ONE_FX)) return ONE_FX;
            else if (v < -35'(ONE_FX)) return -ONE_FX;
            else return v[31:0];
        end
    endfunction

endpackage

// File: rtl/core/trs_model_matrix_builder.sv
// TRS model-matrix builder: pose in, four matrix columns out.
// Sustained pose rate is bounded by the single result channel, which
// carries four column beats per pose. Poses enter a stall-together
// pipeline; a 4-column serializer with a two-slot buffer drains it.
// Reset (aresetn low, sync) clears the valids and column counter only.
module trs_model_matrix_builder (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  trs_pkg::pose_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output trs_pkg::column_t m_data
);
    import trs_pkg::*;

    localparam int DEPTH = NUM_STEPS + 7;

    typedef struct packed {
        logic signed [31:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;
        logic signed [31:0] tx, ty, tz;
    } mat_t;

    // pipeline advance: whole pipe moves when the output buffer has room
    logic        en;
    logic [DEPTH-1:0] vld_reg;
    logic        buf_full;
    assign en      = !buf_full;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    // trig units
    logic signed [31:0] sx, cx, sy, cy, sz, cz;
    trs_trig u_tx (.aclk, .en, .angle(s_data.angle_x), .sin_o(sx), .cos_o(cx));
    trs_trig u_ty (.aclk, .en, .angle(s_data.angle_y), .sin_o(sy), .cos_o(cy));
    trs_trig u_tz (.aclk, .en, .angle(s_data.angle_z), .sin_o(sz), .cos_o(cz));

    // scale and shift ride alongside the trig pipe
    localparam int TRIG_LAT = NUM_STEPS + 4;
    pose_t pd_reg [TRIG_LAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            pd_reg[0] <= s_data;
            for (int k = 1; k < TRIG_LAT; k++) pd_reg[k] <= pd_reg[k-1];
        end
    end

    // stage P1: first products
    logic signed [31:0] sysx_reg, sycx_reg, czcy_reg, szcy_reg, nsy_reg;
    logic signed [31:0] cycx_reg, cysx_reg, czcx_reg, szcx_reg, czsx_reg, szsx_reg;
    logic signed [31:0] p1s_reg [3];
    logic signed [31:0] p1t_reg [3];
    logic signed [31:0] p1cz_reg, p1sz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sysx_reg <= 32'(fx_mul(sy, sx));
            sycx_reg <= 32'(fx_mul(sy, cx));
            czcy_reg <= 32'(fx_mul(cz, cy));
            szcy_reg <= 32'(fx_mul(sz, cy));
            nsy_reg  <= -sy;
            cycx_reg <= 32'(fx_mul(cy, cx));
            cysx_reg <= 32'(fx_mul(cy, sx));
            czcx_reg <= 32'(fx_mul(cz, cx));
            szcx_reg <= 32'(fx_mul(sz, cx));
            czsx_reg <= 32'(fx_mul(cz, sx));
            szsx_reg <= 32'(fx_mul(sz, sx));
            p1cz_reg <= cz;
            p1sz_reg <= sz;
            p1s_reg[0] <= pd_reg[TRIG_LAT-1].scale_x;
            p1s_reg[1] <= pd_reg[TRIG_LAT-1].scale_y;
            p1s_reg[2] <= pd_reg[TRIG_LAT-1].scale_z;
            p1t_reg[0] <= pd_reg[TRIG_LAT-1].shift_x;
            p1t_reg[1] <= pd_reg[TRIG_LAT-1].shift_y;
            p1t_reg[2] <= pd_reg[TRIG_LAT-1].shift_z;
        end
    end

    // stage P2: rotation matrix
    logic signed [31:0] r_reg [9];
    logic signed [31:0] p2s_reg [3];
    logic signed [31:0] p2t_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= czcy_reg;
            r_reg[1] <= szcy_reg;
            r_reg[2] <= nsy_reg;
            r_reg[3] <= 32'(fx_mul(p1cz_reg, sysx_reg) - 48'(szcx_reg));
            r_reg[4] <= 32'(fx_mul(p1sz_reg, sysx_reg) + 48'(czcx_reg));
            r_reg[5] <= cysx_reg;
            r_reg[6] <= 32'(fx_mul(p1cz_reg, sycx_reg) + 48'(szsx_reg));
            r_reg[7] <= 32'(fx_mul(p1sz_reg, sycx_reg) - 48'(czsx_reg));
            r_reg[8] <= cycx_reg;
            p2s_reg <= p1s_reg;
            p2t_reg <= p1t_reg;
        end
    end

    // stage P3: scale and saturate
    mat_t mat_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg.c00 <= sat32(fx_mul(r_reg[0], p2s_reg[0]));
            mat_reg.c01 <= sat32(fx_mul(r_reg[1], p2s_reg[0]));
            mat_reg.c02 <= sat32(fx_mul(r_reg[2], p2s_reg[0]));
            mat_reg.c10 <= sat32(fx_mul(r_reg[3], p2s_reg[1]));
            mat_reg.c11 <= sat32(fx_mul(r_reg[4], p2s_reg[1]));
            mat_reg.c12 <= sat32(fx_mul(r_reg[5], p2s_reg[1]));
            mat_reg.c20 <= sat32(fx_mul(r_reg[6], p2s_reg[2]));
            mat_reg.c21 <= sat32(fx_mul(r_reg[7], p2s_reg[2]));
            mat_reg.c22 <= sat32(fx_mul(r_reg[8], p2s_reg[2]));
            mat_reg.tx  <= p2t_reg[0];
            mat_reg.ty  <= p2t_reg[1];
            mat_reg.tz  <= p2t_reg[2];
        end
    end

    // output buffer: active matrix being serialized plus one spare
    mat_t        act_reg, spare_reg;
    logic        act_vld_reg, spare_vld_reg;
    logic [1:0]  col_reg;
    logic        in_vld, col_done;
    assign in_vld   = en && vld_reg[DEPTH-1];
    assign buf_full = spare_vld_reg;
    assign col_done = act_vld_reg && m_ready && (col_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_vld_reg   <= 1'b0;
            spare_vld_reg <= 1'b0;
            col_reg       <= '0;
        end else begin
            if (act_vld_reg && m_ready) col_reg <= col_reg + 2'd1;
            if (!act_vld_reg || col_done) begin
                if (spare_vld_reg) begin
                    act_reg       <= spare_reg;
                    act_vld_reg   <= 1'b1;
                    spare_vld_reg <= in_vld;
                    if (in_vld) spare_reg <= mat_reg;
                end else begin
                    act_vld_reg <= in_vld;
                    if (in_vld) act_reg <= mat_reg;
                end
            end else if (in_vld) begin
                spare_reg     <= mat_reg;
                spare_vld_reg <= 1'b1;
            end
        end
    end

    // column mux
    always_comb begin
        m_valid             = act_vld_reg;
        m_data.column_index = col_reg;
        m_data.last_column  = (col_reg == 2'd3);
        m_data.entry_row3   = '0;
        case (col_reg)
            2'd0: begin
                m_data.entry_row0 = act_reg.c00;
                m_data.entry_row1 = act_reg.c01;
                m_data.entry_row2 = act_reg.c02;
            end
            2'd1: begin
                m_data.entry_row0 = act_reg.c10;
                m_data.entry_row1 = act_reg.c11;
                m_data.entry_row2 = act_reg.c12;
            end
            2'd2: begin
                m_data.entry_row0 = act_reg.c20;
                m_data.entry_row1 = act_reg.c21;
                m_data.entry_row2 = act_reg.c22;
            end
            default: begin
                m_data.entry_row0 = act_reg.tx;
                m_data.entry_row1 = act_reg.ty;
                m_data.entry_row2 = act_reg.tz;
                m_data.entry_row3 = ONE_FX;
            end
        endcase
    end

endmodule

// File: rtl/core/trs_trig.sv
// Pipelined sine/cosine of one angle in degrees: mod-360 reduction over two
// stages, degree-to-radian multiply, one CORDIC step per stage. Uses trs_pkg.
module trs_trig (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_o,
    output logic signed [31:0] cos_o
);
    import trs_pkg::*;

    localparam int NS = NUM_STEPS;

    // stage A: quotient estimate by reciprocal of the full turn
    // angle / FULL_TURN ~ angle * floor(2^56/FULL_TURN) >> 56 (error <= 1)
    localparam logic [63:0] RECIP = 64'((64'd1 << 56) / 64'(FULL_TURN));
    logic signed [31:0] ang_a_reg;
    logic signed [40:0] quo_a_reg;
    logic signed [96:0] qprod;
    always_comb qprod = 97'(angle) * 97'(signed'({1'b0, RECIP}));
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_a_reg <= angle;
            quo_a_reg <= 41'(qprod >>> 56);
        end
    end

    // stage B: remainder, fixed up into [0, full)
    logic signed [40:0] rem_b_reg;
    logic signed [40:0] rem_raw, rem_fix;
    always_comb begin
        rem_raw = 41'(ang_a_reg) - quo_a_reg * FULL_TURN;
        rem_fix = rem_raw;
        if (rem_fix < 0) rem_fix = rem_fix + FULL_TURN;
        if (rem_fix >= FULL_TURN) rem_fix = rem_fix - FULL_TURN;
    end
    always_ff @(posedge aclk) begin
        if (en) rem_b_reg <= rem_fix;
    end

    // stage C: fold to [-90, 90], magnitude times pi/180
    logic signed [40:0] theta;
    logic               flip_c;
    logic [40:0]        mag;
    logic [67:0]        radp;
    logic signed [33:0] rad_c_reg;
    logic               flip_c_reg;
    always_comb begin
        flip_c = 1'b0;
        if (rem_b_reg > QUARTER && rem_b_reg < 3 * QUARTER) begin
            theta  = rem_b_reg - 2 * QUARTER;
            flip_c = 1'b1;
        end else if (rem_b_reg >= 3 * QUARTER) begin
            theta = rem_b_reg - FULL_TURN;
        end else begin
            theta = rem_b_reg;
        end
        mag  = (theta < 0) ? 41'(-theta) : 41'(theta);
        radp = (68'(mag) * 68'(DEG_TO_RAD_Q32) + (68'd1 << (FRAC_BITS + 1)))
               >> (FRAC_BITS + 2);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_c_reg  <= (theta < 0) ? -34'(radp) : 34'(radp);
            flip_c_reg <= flip_c;
        end
    end

    // CORDIC stages, one rotation each
    logic signed [33:0] x_reg [NS+1];
    logic signed [33:0] y_reg [NS+1];
    logic signed [33:0] z_reg [NS+1];
    logic               f_reg [NS+1];
    always_comb begin
        x_reg[0] = CORDIC_GAIN_Q30;
        y_reg[0] = '0;
        z_reg[0] = rad_c_reg;
        f_reg[0] = flip_c_reg;
    end
    for (genvar i = 0; i < NS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                f_reg[i+1] <= f_reg[i];
            end
        end
    end

    // output: quadrant sign and format conversion
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_o <= to_frac(f_reg[NS] ? -y_reg[NS] : y_reg[NS]);
            cos_o <= to_frac(f_reg[NS] ? -x_reg[NS] : x_reg[NS]);
        end
    end

endmodule

// File: rtl/core/trs_checker.sv
// Port-level checker for the TRS model-matrix builder, bound to the top.
// Depends on trs_pkg.
module trs_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input trs_pkg::column_t m_data
);
    import trs_pkg::*;

    // columns come out in order 0..3
    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.column_index != 2'd3) |=>
        (m_data.column_index == $past(m_data.column_index) + 2'd1))
        else $error("column order broken");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_column == (m_data.column_index == 2'd3)))
        else $error("last_column mismatch");

    a_row3: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.column_index != 2'd3) |-> (m_data.entry_row3 == 32'sd0))
        else $error("row3 nonzero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (.*);

// File: tb/tb_trs_model_matrix_builder.sv
// Testbench for trs_model_matrix_builder: drives random and directed poses,
// predicts the four model-matrix columns and checks every result beat.
// Depends on trs_pkg (pose_t, column_t) and the block itself.

// Holds predicted columns and compares result beats against them.
class column_scoreboard;
    trs_pkg::column_t pending[$];
    int errors;
    int checked;

    static const longint ATAN_TBL[30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

    function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint qmul(longint a, longint b);
        return floor_shift(a * b + (64'sd1 <<< (trs_pkg::FRAC_BITS - 1)),
                           trs_pkg::FRAC_BITS);
    endfunction

    function longint q30_to_fx(longint q);
        longint one;
        longint v;
        int sh;
        one = 64'sd1 <<< trs_pkg::FRAC_BITS;
        sh = 30 - trs_pkg::FRAC_BITS;
        v = floor_shift(q + (64'sd1 <<< (sh - 1)), sh);
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v;
    endfunction

    // Angle reduction into [-90, 90] then CORDIC rotation.
    function void trig(logic signed [31:0] ang, output longint s, output longint c);
        longint full, quarter, r, theta, mag, rad, x, y, z, dx, dy;
        bit flip;
        full = 64'sd360 <<< trs_pkg::FRAC_BITS;
        quarter = 64'sd90 <<< trs_pkg::FRAC_BITS;
        r = longint'(ang) % full;
        flip = 0;
        if (r < 0) r += full;
        if (r > quarter && r < 3 * quarter) begin
            theta = r - 2 * quarter;
            flip = 1;
        end else if (r >= 3 * quarter) begin
            theta = r - full;
        end else begin
            theta = r;
        end
        mag = (theta < 0) ? -theta : theta;
        rad = (mag * 64'sd74961321 + (64'sd1 <<< (trs_pkg::FRAC_BITS + 1)))
              >>> (trs_pkg::FRAC_BITS + 2);
        if (theta < 0) rad = -rad;
        x = 64'sd652032874;
        y = 0;
        z = rad;
        for (int i = 0; i < trs_pkg::TRIG_ITERATIONS && i < 30; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = q30_to_fx(y);
        c = q30_to_fx(x);
    endfunction

    // Build the four expected columns of one accepted pose.
    function void note_pose(trs_pkg::pose_t p);
        longint sx, cx, sy, cy, sz, cz, sysx, sycx;
        longint rot[3][3];
        longint sc[3];
        trs_pkg::column_t col;
        trig(p.angle_x, sx, cx);
        trig(p.angle_y, sy, cy);
        trig(p.angle_z, sz, cz);
        sc[0] = p.scale_x; sc[1] = p.scale_y; sc[2] = p.scale_z;
        sysx = qmul(sy, sx);
        sycx = qmul(sy, cx);
        rot[0][0] = qmul(cz, cy);
        rot[0][1] = qmul(sz, cy);
        rot[0][2] = -sy;
        rot[1][0] = qmul(cz, sysx) - qmul(sz, cx);
        rot[1][1] = qmul(sz, sysx) + qmul(cz, cx);
        rot[1][2] = qmul(cy, sx);
        rot[2][0] = qmul(cz, sycx) + qmul(sz, sx);
        rot[2][1] = qmul(sz, sycx) - qmul(cz, sx);
        rot[2][2] = qmul(cy, cx);
        for (int j = 0; j < 3; j++) begin
            col.column_index = j[1:0];
            col.entry_row0 = 32'(clamp32(qmul(rot[j][0], sc[j])));
            col.entry_row1 = 32'(clamp32(qmul(rot[j][1], sc[j])));
            col.entry_row2 = 32'(clamp32(qmul(rot[j][2], sc[j])));
            col.entry_row3 = 0;
            col.last_column = 1'b0;
            pending.push_back(col);
        end
        col.column_index = 2'd3;
        col.entry_row0 = p.shift_x;
        col.entry_row1 = p.shift_y;
        col.entry_row2 = p.shift_z;
        col.entry_row3 = trs_pkg::ONE_FX;
        col.last_column = 1'b1;
        pending.push_back(col);
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_column(trs_pkg::column_t got);
        trs_pkg::column_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected column beat %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.column_index !== want.column_index) begin
            $display("%0t: column_index exp %0d got %0d", $time,
                     want.column_index, got.column_index);
            errors++;
        end
        if (got.entry_row0 !== want.entry_row0) begin
            $display("%0t: row0 exp %h got %h", $time, want.entry_row0, got.entry_row0);
            errors++;
        end
        if (got.entry_row1 !== want.entry_row1) begin
            $display("%0t: row1 exp %h got %h", $time, want.entry_row1, got.entry_row1);
            errors++;
        end
        if (got.entry_row2 !== want.entry_row2) begin
            $display("%0t: row2 exp %h got %h", $time, want.entry_row2, got.entry_row2);
            errors++;
        end
        if (got.entry_row3 !== want.entry_row3) begin
            $display("%0t: row3 exp %h got %h", $time, want.entry_row3, got.entry_row3);
            errors++;
        end
        if (got.last_column !== want.last_column) begin
            $display("%0t: last_column exp %b got %b", $time,
                     want.last_column, got.last_column);
            errors++;
        end
    endfunction
endclass

module tb_trs_model_matrix_builder;
    import trs_pkg::*;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    pose_t   s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    column_t m_data;

    column_scoreboard board = new();
    pose_t   poses[$];
    int      poses_sent = 0;
    int      stall_mode = 0;
    bit      stim_done = 0;

    trs_model_matrix_builder i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'(90 << 16) * $urandom_range(0, 8) - 32'(360 << 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic pose_t mk_pose(logic [31:0] s, logic [31:0] a, logic [31:0] t);
        pose_t p;
        p.scale_x = s; p.scale_y = s; p.scale_z = s;
        p.angle_x = a; p.angle_y = a; p.angle_z = a;
        p.shift_x = t; p.shift_y = t; p.shift_z = t;
        return p;
    endfunction

    // Send one pose; holds valid until accepted.
    task automatic send_pose(pose_t p);
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pose(p);
        poses_sent++;
    endtask

    // Receiver stall pattern, changing style every so often.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_column(m_data);
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int gap;
        int burst;
        int waited;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, quadrant boundaries, saturation.
        poses.push_back(mk_pose(32'h0001_0000, 32'h0, 32'h0));
        poses.push_back(mk_pose(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
        poses.push_back(mk_pose(32'h8000_0000, 32'h0, 32'h8000_0000));
        poses.push_back(mk_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        poses.push_back(mk_pose(32'h8000_0000, 32'h8000_0000, 32'h0));
        poses.push_back(mk_pose(32'h0001_0000, 32'(90 << 16), 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, 32'(180 << 16), 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, 32'(270 << 16), 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, 32'(360 << 16), 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, -32'(90 << 16), 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, 32'(90 << 16) + 1, 32'h1));
        poses.push_back(mk_pose(32'h0001_0000, 32'(270 << 16) - 1, 32'h1));
        poses.push_back(mk_pose(32'hFFFF_0000, 32'(45 << 16), 32'h5555_5555));
        poses.push_back(mk_pose(32'h5555_5555, 32'(30 << 16), 32'hAAAA_AAAA));
        poses.push_back(mk_pose(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0));
        for (int k = 0; k < 380; k++) begin
            pose_t p;
            p.scale_x = rand_word(); p.scale_y = rand_word(); p.scale_z = rand_word();
            p.angle_x = rand_word(); p.angle_y = rand_word(); p.angle_z = rand_word();
            p.shift_x = rand_word(); p.shift_y = rand_word(); p.shift_z = rand_word();
            poses.push_back(p);
        end

        // Bursts of back-to-back poses separated by random gaps.
        while (poses.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && poses.size() > 0) begin
                send_pose(poses.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (NUM_STEPS + 40) @(posedge aclk);

        $display("Sent %0d poses, checked %0d column beats.", poses_sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: trs_model_matrix_builder.f
rtl/core/trs_pkg.sv
rtl/core/trs_trig.sv
rtl/core/trs_model_matrix_builder.sv
rtl/core/trs_checker.sv
tb/tb_trs_model_matrix_builder.sv
